// ----- sv/tgq_pkg.sv -----
package tgq_pkg;

    // Atlas geometry: cells per row and rows of cells
    localparam int ATLAS_COLUMNS = 32;
    localparam int ATLAS_ROWS    = 4;

    // Column and row indexes hold one past the last cell (right / bottom edge)
    localparam int COL_W = $clog2(ATLAS_COLUMNS + 1);
    localparam int ROW_W = $clog2(ATLAS_ROWS + 1);

    // Field widths
    localparam int CODE_W   = 8;
    localparam int REG_W    = 17;   // Q1.16 registers
    localparam int CURSOR_W = 20;   // Q4.16 cursor
    localparam int POS_W    = 20;   // signed Q3.16
    localparam int TEXU_W   = 22;   // Q6.16
    localparam int TEXV_W   = 19;   // Q3.16
    localparam int BASE_W   = 23;   // signed intermediate for clip-space math
    localparam int TU_PROD_W = COL_W + REG_W;
    localparam int TV_PROD_W = ROW_W + REG_W;
    localparam int CFG_IDX_W = 3;

    // Fixed-point constants
    localparam logic signed [BASE_W-1:0] POS_ONE = 23'sd65536;
    localparam logic signed [BASE_W-1:0] POS_MAX = 23'sd524287;
    localparam logic signed [BASE_W-1:0] POS_MIN = -23'sd524288;
    localparam logic [31:0] TEXU_MAX = 32'd4194303;
    localparam logic [31:0] TEXV_MAX = 32'd524287;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd11;
    localparam logic [CODE_W-1:0] CODE_FF    = 8'd12;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;
    localparam logic [CODE_W-1:0] CODE_TILDE = 8'd126;

    // Corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_GLYPH_W  = 3'd2,
        REG_GLYPH_H  = 3'd3,
        REG_U_STEP   = 3'd4,
        REG_V_STEP   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [REG_W-1:0] origin_x;
        logic [REG_W-1:0] origin_y;
        logic [REG_W-1:0] glyph_w;
        logic [REG_W-1:0] glyph_h;
        logic [REG_W-1:0] u_step;
        logic [REG_W-1:0] v_step;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              start_of_text;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TEXU_W-1:0]       tex_u;
        logic [TEXV_W-1:0]       tex_v;
        logic [1:0]              corner;
        logic                    last_vertex;
    } vertex_t;

    // Per-glyph quad handed from the cursor stage to the vertex stage
    typedef struct packed {
        logic signed [BASE_W-1:0] bx;
        logic signed [BASE_W-1:0] by;
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
    } quad_t;

    function automatic logic [CURSOR_W-1:0] sat_cursor(input logic [CURSOR_W:0] v);
        logic [CURSOR_W-1:0] r;
        begin
            r = v[CURSOR_W] ? {CURSOR_W{1'b1}} : v[CURSOR_W-1:0];
            return r;
        end
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [BASE_W-1:0] v);
        logic [POS_W-1:0] r;
        begin
            if (v > POS_MAX)
                r = POS_MAX[POS_W-1:0];
            else if (v < POS_MIN)
                r = POS_MIN[POS_W-1:0];
            else
                r = v[POS_W-1:0];
            return r;
        end
    endfunction

    function automatic logic [TEXU_W-1:0] sat_tex_u(input logic [31:0] v);
        logic [TEXU_W-1:0] r;
        begin
            r = (v > TEXU_MAX) ? TEXU_MAX[TEXU_W-1:0] : v[TEXU_W-1:0];
            return r;
        end
    endfunction

    function automatic logic [TEXV_W-1:0] sat_tex_v(input logic [31:0] v);
        logic [TEXV_W-1:0] r;
        begin
            r = (v > TEXV_MAX) ? TEXV_MAX[TEXV_W-1:0] : v[TEXV_W-1:0];
            return r;
        end
    endfunction

endpackage

// ----- sv/tgq_cursor.sv -----
module tgq_cursor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  tgq_pkg::item_t item,
    input  tgq_pkg::cfg_t  cfg,
    output logic           printable,
    output tgq_pkg::quad_t quad
);

    logic [tgq_pkg::CURSOR_W-1:0] cursor_x_reg, cursor_x_next;
    logic [tgq_pkg::CURSOR_W-1:0] cursor_y_reg, cursor_y_next;

    logic [tgq_pkg::CURSOR_W-1:0] cx_base;
    logic [tgq_pkg::CURSOR_W-1:0] cy_base;
    logic [tgq_pkg::CURSOR_W-1:0] origin_x_ext;
    logic [tgq_pkg::CODE_W-1:0]   code;
    logic [tgq_pkg::CODE_W-1:0]   code_eff;
    logic                         is_tab;
    logic                         is_newline;
    logic [tgq_pkg::CURSOR_W:0]   tab_sum;
    logic [tgq_pkg::CURSOR_W:0]   adv_sum;
    logic [tgq_pkg::CURSOR_W:0]   line_sum;

    // Start of text moves the cursor to the origin before the code acts
    always_comb
    begin
        origin_x_ext = tgq_pkg::CURSOR_W'(cfg.origin_x);
        cx_base      = item.start_of_text ? origin_x_ext
                                          : cursor_x_reg;
        cy_base      = item.start_of_text ? tgq_pkg::CURSOR_W'(cfg.origin_y)
                                          : cursor_y_reg;
    end

    // Decode the character
    always_comb
    begin
        code       = item.char_code;
        is_tab     = (code == tgq_pkg::CODE_TAB);
        is_newline = (code == tgq_pkg::CODE_LF) || (code == tgq_pkg::CODE_FF) ||
                     (code == tgq_pkg::CODE_CR);
        printable  = !is_tab && !is_newline;
        if ((code < tgq_pkg::CODE_SPACE) || (code > tgq_pkg::CODE_TILDE))
            code_eff = tgq_pkg::CODE_SPACE;
        else
            code_eff = code;
    end

    // Quad base: clip-space center line and atlas cell
    always_comb
    begin
        quad.bx  = $signed({2'b00, cx_base, 1'b0}) - tgq_pkg::POS_ONE;
        quad.by  = tgq_pkg::POS_ONE - $signed({2'b00, cy_base, 1'b0});
        quad.col = tgq_pkg::COL_W'(code_eff % tgq_pkg::ATLAS_COLUMNS);
        quad.row = tgq_pkg::ROW_W'((code_eff / tgq_pkg::ATLAS_COLUMNS)
                                   % tgq_pkg::ATLAS_ROWS);
    end

    // Cursor moves: tab, new line, glyph advance
    always_comb
    begin
        tab_sum  = {1'b0, cx_base} + {1'b0, cfg.origin_x, 3'b000};
        adv_sum  = {1'b0, cx_base} + (tgq_pkg::CURSOR_W + 1)'(cfg.glyph_w);
        line_sum = {1'b0, cy_base} + (tgq_pkg::CURSOR_W + 1)'(cfg.glyph_h);

        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (accept)
        begin
            if (is_tab)
            begin
                cursor_x_next = tgq_pkg::sat_cursor(tab_sum);
                cursor_y_next = cy_base;
            end
            else if (is_newline)
            begin
                cursor_x_next = origin_x_ext;
                cursor_y_next = tgq_pkg::sat_cursor(line_sum);
            end
            else
            begin
                cursor_x_next = tgq_pkg::sat_cursor(adv_sum);
                cursor_y_next = cy_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

// ----- sv/tgq_vertex.sv -----
module tgq_vertex (
    input  logic                clk,
    input  logic                rst_n,
    input  tgq_pkg::cfg_t       cfg,
    input  tgq_pkg::quad_t      quad_in,
    input  logic                quad_load,
    output logic                quad_free,
    output logic                vtx_valid,
    input  logic                vtx_stall,
    output tgq_pkg::vertex_t    vtx
);

    logic                  quad_valid_reg, quad_valid_next;
    tgq_pkg::quad_t        quad_reg, quad_next;
    logic [1:0]            corner_reg, corner_next;
    logic                  out_valid_reg, out_valid_next;
    tgq_pkg::vertex_t      out_reg, out_next;

    logic                           out_free;
    logic                           emit;
    logic                           last;
    logic                           right;
    logic                           bottom;
    logic signed [tgq_pkg::BASE_W-1:0] gw_ext;
    logic signed [tgq_pkg::BASE_W-1:0] gh_ext;
    logic signed [tgq_pkg::BASE_W-1:0] px;
    logic signed [tgq_pkg::BASE_W-1:0] py;
    logic [tgq_pkg::COL_W-1:0]      cu;
    logic [tgq_pkg::ROW_W-1:0]      cv;
    logic [tgq_pkg::TU_PROD_W-1:0]  tu_prod;
    logic [tgq_pkg::TV_PROD_W-1:0]  tv_prod;

    // Output register is free when empty or drained this cycle
    always_comb
    begin
        out_free  = !out_valid_reg || !vtx_stall;
        emit      = quad_valid_reg && out_free;
        last      = (corner_reg == tgq_pkg::CORNER_BR);
        quad_free = !quad_valid_reg || (emit && last);
    end

    // Corner geometry for the current vertex
    always_comb
    begin
        right   = corner_reg[0];
        bottom  = corner_reg[1];
        gw_ext  = $signed({6'b000000, cfg.glyph_w});
        gh_ext  = $signed({6'b000000, cfg.glyph_h});
        px      = right  ? (quad_reg.bx + gw_ext) : (quad_reg.bx - gw_ext);
        py      = bottom ? (quad_reg.by - gh_ext) : (quad_reg.by + gh_ext);
        cu      = quad_reg.col + tgq_pkg::COL_W'(right);
        cv      = quad_reg.row + tgq_pkg::ROW_W'(bottom);
        tu_prod = tgq_pkg::TU_PROD_W'(cu) * tgq_pkg::TU_PROD_W'(cfg.u_step);
        tv_prod = tgq_pkg::TV_PROD_W'(cv) * tgq_pkg::TV_PROD_W'(cfg.v_step);

        out_next.pos_x       = tgq_pkg::sat_pos(px);
        out_next.pos_y       = tgq_pkg::sat_pos(py);
        out_next.tex_u       = tgq_pkg::sat_tex_u(32'(tu_prod));
        out_next.tex_v       = tgq_pkg::sat_tex_v(32'(tv_prod));
        out_next.corner      = corner_reg;
        out_next.last_vertex = last;
    end

    // Quad holding register and corner sequencer
    always_comb
    begin
        quad_valid_next = quad_valid_reg;
        quad_next       = quad_reg;
        corner_next     = corner_reg;
        if (emit)
            corner_next = corner_reg + 2'd1;
        if (emit && last)
            quad_valid_next = 1'b0;
        if (quad_load)
        begin
            quad_valid_next = 1'b1;
            quad_next       = quad_in;
        end
        out_valid_next = emit || (out_valid_reg && vtx_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_valid_reg <= 1'b0;
            corner_reg     <= tgq_pkg::CORNER_TL;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            quad_valid_reg <= quad_valid_next;
            corner_reg     <= corner_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        if (emit)
            out_reg <= out_next;
    end

    assign vtx_valid = out_valid_reg;
    assign vtx       = out_reg;

    // A new quad never overwrites one that still has corners to send
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        quad_load |-> quad_free)
        else $error("quad loaded while previous quad still busy");

    // Every quad starts at the top-left corner
    a_start_tl: assert property (@(posedge clk) disable iff (!rst_n)
        quad_load |=> (corner_reg == tgq_pkg::CORNER_TL))
        else $error("quad did not start at top-left corner");

    // The quad register empties after its fourth vertex unless refilled
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last && !quad_load) |=> !quad_valid_reg)
        else $error("quad not released after last corner");

    // A vertex is only produced from a held quad
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(quad_valid_reg))
        else $error("vertex produced without a quad");

endmodule

// ----- sv/text_glyph_quad_generator_top.sv -----
// Text glyph quad generator.
// Item channel (item_valid / item_stall / item): one character code per beat,
// with start_of_text moving the cursor to the configured origin first.
// Vertex channel (vtx_valid / vtx_stall / vtx): a printable code (anything
// but tab, line feed, form feed, carriage return) yields four vertex beats in
// the order top-left, top-right, bottom-left, bottom-right; last_vertex marks
// the fourth. Tab and line-break codes only move the cursor and yield no beat.
// Each printable character is registered as a quad in the quad register, and
// each of its corners in turn in the single vertex output register, which
// sends one corner per cycle while vtx_stall is low; the next character is
// taken in the cycle the fourth corner leaves the quad register.
// Configuration: cfg_en / cfg_index / cfg_data write one register per cycle,
// and the user must write only while the block is idle (the block does not
// enforce it). Unknown indexes are ignored. Reset clears the cursor to zero
// (not to the origin) and the configuration registers to zero and drops
// vtx_valid. While vtx_stall is high the presented vertex holds and
// item_stall rises once the pending quad can no longer advance.
module text_glyph_quad_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  tgq_pkg::item_t                item,
    output logic                          vtx_valid,
    input  logic                          vtx_stall,
    output tgq_pkg::vertex_t              vtx,
    input  logic                          cfg_en,
    input  logic [tgq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgq_pkg::REG_W-1:0]     cfg_data
);

    tgq_pkg::cfg_t     cfg_reg, cfg_next;
    tgq_pkg::quad_t    quad;
    logic              quad_load;
    logic              quad_free;
    logic              accept;
    logic              printable;

    // Configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_en)
        begin
            case (tgq_pkg::cfg_index_t'(cfg_index))
                tgq_pkg::REG_ORIGIN_X: cfg_next.origin_x = cfg_data;
                tgq_pkg::REG_ORIGIN_Y: cfg_next.origin_y = cfg_data;
                tgq_pkg::REG_GLYPH_W:  cfg_next.glyph_w  = cfg_data;
                tgq_pkg::REG_GLYPH_H:  cfg_next.glyph_h  = cfg_data;
                tgq_pkg::REG_U_STEP:   cfg_next.u_step   = cfg_data;
                tgq_pkg::REG_V_STEP:   cfg_next.v_step   = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // Input handshake
    always_comb
    begin
        item_stall = !quad_free;
        accept     = item_valid && !item_stall;
        quad_load  = accept && printable;
    end

    tgq_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg_reg),
        .printable (printable),
        .quad      (quad)
    );

    tgq_vertex u_vertex (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .quad_in   (quad),
        .quad_load (quad_load),
        .quad_free (quad_free),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx)
    );

endmodule

// ----- verif/text_glyph_quad_generator_top_test.sv -----
`timescale 1ns / 1ps

module text_glyph_quad_generator_top_test;

    // Fixed-point limits of the vertex math
    localparam longint ONE_Q16    = 65536;
    localparam longint CURSOR_TOP = 64'hFFFFF;
    localparam longint POS_TOP    = 524287;
    localparam longint POS_BOTTOM = -524288;
    localparam longint TEXU_TOP   = 4194303;
    localparam longint TEXV_TOP   = 524287;
    localparam int     REG_TOP    = 131071;
    localparam logic [tgq_pkg::REG_W-1:0] REG_ALL_ONES = '1;

    // Register indexes with no register behind them
    localparam logic [tgq_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [tgq_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Receiver stall patterns
    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;
    localparam int STALL_HEAVY   = 3;

    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 8;

    // Cursor and quad predictor plus queue of vertices still owed by the block
    class glyph_scoreboard;
        logic [tgq_pkg::REG_W-1:0]    org_x, org_y, glyph_wd, glyph_ht, u_stp, v_stp;
        logic [tgq_pkg::CURSOR_W-1:0] cur_x, cur_y;
        tgq_pkg::vertex_t             owed_vertices[$];
        int                           mismatches;
        int                           vertices_seen;
        int                           chars_taken;

        function new();
            org_x = '0; org_y = '0; glyph_wd = '0; glyph_ht = '0;
            u_stp = '0; v_stp = '0;
            cur_x = '0; cur_y = '0;
            mismatches = 0; vertices_seen = 0; chars_taken = 0;
        endfunction

        function void set_reg(logic [tgq_pkg::CFG_IDX_W-1:0] idx,
                              logic [tgq_pkg::REG_W-1:0] data);
            case (idx)
                tgq_pkg::REG_ORIGIN_X: org_x = data;
                tgq_pkg::REG_ORIGIN_Y: org_y = data;
                tgq_pkg::REG_GLYPH_W:  glyph_wd = data;
                tgq_pkg::REG_GLYPH_H:  glyph_ht = data;
                tgq_pkg::REG_U_STEP:   u_stp = data;
                tgq_pkg::REG_V_STEP:   v_stp = data;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function int pending();
            return owed_vertices.size();
        endfunction

        // Advance the cursor for one accepted character and queue its quad
        function void note_char(tgq_pkg::item_t it);
            logic [tgq_pkg::CODE_W-1:0] code;
            longint                     bx, by, px, py, tu, tv;
            int                         col, row;
            logic [1:0]                 c;
            bit                         right, bottom;
            tgq_pkg::vertex_t           v;
            code = it.char_code;
            chars_taken++;
            if (it.start_of_text)
            begin
                cur_x = tgq_pkg::CURSOR_W'(org_x);
                cur_y = tgq_pkg::CURSOR_W'(org_y);
            end
            if (code == tgq_pkg::CODE_TAB)
            begin
                cur_x = tgq_pkg::CURSOR_W'(clamp(longint'(cur_x) + 8 * longint'(org_x),
                                                 0, CURSOR_TOP));
                return;
            end
            if (code >= tgq_pkg::CODE_LF && code <= tgq_pkg::CODE_CR)
            begin
                cur_x = tgq_pkg::CURSOR_W'(org_x);
                cur_y = tgq_pkg::CURSOR_W'(clamp(longint'(cur_y) + longint'(glyph_ht),
                                                 0, CURSOR_TOP));
                return;
            end
            if (code < tgq_pkg::CODE_SPACE || code > tgq_pkg::CODE_TILDE)
                code = tgq_pkg::CODE_SPACE;
            col = code % tgq_pkg::ATLAS_COLUMNS;
            row = (code / tgq_pkg::ATLAS_COLUMNS) % tgq_pkg::ATLAS_ROWS;
            bx  = 2 * longint'(cur_x) - ONE_Q16;
            by  = ONE_Q16 - 2 * longint'(cur_y);
            for (int j = 0; j < 4; j++)
            begin
                c      = j[1:0];
                right  = (c == tgq_pkg::CORNER_TR) || (c == tgq_pkg::CORNER_BR);
                bottom = (c == tgq_pkg::CORNER_BL) || (c == tgq_pkg::CORNER_BR);
                px = right ? bx + longint'(glyph_wd) : bx - longint'(glyph_wd);
                py = bottom ? by - longint'(glyph_ht) : by + longint'(glyph_ht);
                tu = longint'(col + (right ? 1 : 0)) * longint'(u_stp);
                tv = longint'(row + (bottom ? 1 : 0)) * longint'(v_stp);
                v.pos_x       = tgq_pkg::POS_W'(clamp(px, POS_BOTTOM, POS_TOP));
                v.pos_y       = tgq_pkg::POS_W'(clamp(py, POS_BOTTOM, POS_TOP));
                v.tex_u       = tgq_pkg::TEXU_W'(clamp(tu, 0, TEXU_TOP));
                v.tex_v       = tgq_pkg::TEXV_W'(clamp(tv, 0, TEXV_TOP));
                v.corner      = c;
                v.last_vertex = (c == tgq_pkg::CORNER_BR);
                owed_vertices.push_back(v);
            end
            cur_x = tgq_pkg::CURSOR_W'(clamp(longint'(cur_x) + longint'(glyph_wd),
                                             0, CURSOR_TOP));
        endfunction

        // Compare one vertex beat with the oldest owed vertex
        function void check_vertex(tgq_pkg::vertex_t got);
            tgq_pkg::vertex_t want;
            vertices_seen++;
            if (owed_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: vertex beat with none owed: x=%0d y=%0d u=%0d v=%0d c=%0d l=%0b",
                             $realtime, got.pos_x, got.pos_y, got.tex_u, got.tex_v,
                             got.corner, got.last_vertex);
                return;
            end
            want = owed_vertices.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.tex_u !== want.tex_u || got.tex_v !== want.tex_v ||
                got.corner !== want.corner || got.last_vertex !== want.last_vertex)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: vertex mismatch, want x=%0d y=%0d u=%0d v=%0d c=%0d l=%0b",
                             $realtime, want.pos_x, want.pos_y, want.tex_u, want.tex_v,
                             want.corner, want.last_vertex);
                    $display("           got  x=%0d y=%0d u=%0d v=%0d c=%0d l=%0b",
                             got.pos_x, got.pos_y, got.tex_u, got.tex_v,
                             got.corner, got.last_vertex);
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_stall;
    tgq_pkg::item_t                 item;
    logic                           vtx_valid;
    logic                           vtx_stall;
    tgq_pkg::vertex_t               vtx;
    logic                           cfg_en;
    logic [tgq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tgq_pkg::REG_W-1:0]      cfg_data;

    glyph_scoreboard sb = new();

    int stall_mode;
    int hold_len;
    int stall_tick;
    int settings_used;

    text_glyph_quad_generator_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .vtx_valid  (vtx_valid),
        .vtx_stall  (vtx_stall),
        .vtx        (vtx),
        .cfg_en     (cfg_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Watchdog
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Character beats taken by the block
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_char(item);
    end

    // Vertex beats leaving the block
    always @(posedge clk)
    begin
        if (rst_n && vtx_valid && !vtx_stall)
            sb.check_vertex(vtx);
    end

    // Receiver: long hold-off on request, otherwise the selected stall pattern
    initial
    begin
        vtx_stall  = 1'b0;
        stall_tick = 0;
        forever
        begin
            @(negedge clk);
            stall_tick++;
            if (hold_len > 0)
            begin
                vtx_stall = 1'b1;
                hold_len--;
            end
            else
            begin
                case (stall_mode)
                    STALL_RANDOM:  vtx_stall = ($urandom_range(0, 3) == 0);
                    STALL_PATTERN: vtx_stall = ((stall_tick % 11) >= 7);
                    STALL_HEAVY:   vtx_stall = ($urandom_range(0, 9) < 7);
                    default:       vtx_stall = 1'b0;
                endcase
            end
        end
    end

    function automatic logic [tgq_pkg::REG_W-1:0] rand_reg(int unsigned hi);
        return tgq_pkg::REG_W'($urandom_range(0, hi));
    endfunction

    function automatic tgq_pkg::item_t mk_char(logic [tgq_pkg::CODE_W-1:0] code, logic sot);
        tgq_pkg::item_t it;
        it.char_code     = code;
        it.start_of_text = sot;
        return it;
    endfunction

    // Mostly printable text with line breaks and tabs, some raw bytes
    function automatic tgq_pkg::item_t random_char(bit first);
        tgq_pkg::item_t it;
        int             pick;
        pick = $urandom_range(0, 99);
        it.start_of_text = first ? 1'b1 : ($urandom_range(0, 24) == 0);
        if (pick < 68)
            it.char_code = tgq_pkg::CODE_W'($urandom_range(32, 126));
        else if (pick < 78)
        begin
            case ($urandom_range(0, 2))
                0:       it.char_code = tgq_pkg::CODE_LF;
                1:       it.char_code = tgq_pkg::CODE_FF;
                default: it.char_code = tgq_pkg::CODE_CR;
            endcase
        end
        else if (pick < 85)
            it.char_code = tgq_pkg::CODE_TAB;
        else
            it.char_code = tgq_pkg::CODE_W'($urandom_range(0, 255));
        return it;
    endfunction

    // Present one character and hold it until taken
    task automatic drive_char(tgq_pkg::item_t it);
        item       = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        item_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Stop sending until every owed vertex is out and the block has settled
    task automatic drain();
        item_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [tgq_pkg::CFG_IDX_W-1:0] idx,
                             logic [tgq_pkg::REG_W-1:0] data);
        cfg_en    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_en = 1'b0;
    endtask

    task automatic load_setting(logic [tgq_pkg::REG_W-1:0] ox, logic [tgq_pkg::REG_W-1:0] oy,
                                logic [tgq_pkg::REG_W-1:0] gw, logic [tgq_pkg::REG_W-1:0] gh,
                                logic [tgq_pkg::REG_W-1:0] us, logic [tgq_pkg::REG_W-1:0] vs);
        drain();
        write_reg(tgq_pkg::REG_ORIGIN_X, ox);
        write_reg(tgq_pkg::REG_ORIGIN_Y, oy);
        write_reg(tgq_pkg::REG_GLYPH_W, gw);
        write_reg(tgq_pkg::REG_GLYPH_H, gh);
        write_reg(tgq_pkg::REG_U_STEP, us);
        write_reg(tgq_pkg::REG_V_STEP, vs);
        // writes to unused indexes must leave every register alone
        write_reg(REG_SPARE_6, rand_reg(REG_TOP));
        write_reg(REG_SPARE_7, rand_reg(REG_TOP));
        settings_used++;
    endtask

    // Random text in bursts; max_gap of zero keeps the sender always offering
    task automatic send_text(int n, int max_gap);
        int burst_left;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            drive_char(random_char(i == 0));
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if (max_gap > 0)
                    pause_sender($urandom_range(1, max_gap));
            end
        end
    endtask

    initial
    begin
        bit failed;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_en        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        stall_mode    = STALL_NONE;
        hold_len      = 0;
        settings_used = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset registers, cursor still at zero
        drive_char(mk_char(8'd65, 1'b0));
        drive_char(mk_char(tgq_pkg::CODE_TAB, 1'b1));
        drive_char(mk_char(8'd66, 1'b0));

        // Directed text on a typical atlas setting
        load_setting(17'h00800, 17'h00800, 17'h00400, 17'h00800, 17'h00800, 17'h04000);
        drive_char(mk_char(8'd65, 1'b1));
        drive_char(mk_char(tgq_pkg::CODE_SPACE, 1'b0));
        drive_char(mk_char(tgq_pkg::CODE_TILDE, 1'b0));
        drive_char(mk_char(8'd0, 1'b0));
        drive_char(mk_char(8'd31, 1'b0));
        drive_char(mk_char(8'd127, 1'b0));
        drive_char(mk_char(8'd255, 1'b0));
        drive_char(mk_char(8'd9, 1'b0));
        drive_char(mk_char(tgq_pkg::CODE_LF, 1'b0));
        drive_char(mk_char(8'd66, 1'b0));
        drive_char(mk_char(tgq_pkg::CODE_TAB, 1'b0));
        drive_char(mk_char(8'd67, 1'b1));
        drive_char(mk_char(tgq_pkg::CODE_FF, 1'b0));
        drive_char(mk_char(tgq_pkg::CODE_CR, 1'b0));
        drive_char(mk_char(8'd14, 1'b0));
        drive_char(mk_char(8'd95, 1'b0));
        drive_char(mk_char(8'd96, 1'b0));

        // Random text across settings and receiver behaviors
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: load_setting(17'h00800, 17'h00800, 17'h00400, 17'h00800,
                                17'h00800, 17'h04000);
                1: load_setting(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES,
                                REG_ALL_ONES, REG_ALL_ONES);
                2: load_setting('0, '0, '0, '0, '0, '0);
                4: load_setting(rand_reg(4096), rand_reg(4096),
                                rand_reg(4096), rand_reg(8192),
                                rand_reg(4096), rand_reg(16384));
                default: load_setting(rand_reg(REG_TOP), rand_reg(REG_TOP),
                                      rand_reg(REG_TOP), rand_reg(REG_TOP),
                                      rand_reg(REG_TOP), rand_reg(REG_TOP));
            endcase
            stall_mode = p % 4;
            if (p == 3)
            begin
                // receiver holds off while the sender keeps offering
                hold_len = 80;
                send_text(12, 0);
            end
            send_text(50, (p == 0) ? 0 : 6);
        end

        drain();
        failed = (sb.mismatches != 0) || (sb.pending() != 0);
        $display("Covered %0d characters and %0d vertex beats over %0d register settings,",
                 sb.chars_taken, sb.vertices_seen, settings_used);
        $display("including saturation, control codes and a long receiver hold-off; %0d mismatches",
                 sb.mismatches);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tgq_pkg.sv
sv/tgq_cursor.sv
sv/tgq_vertex.sv
sv/text_glyph_quad_generator_top.sv
verif/text_glyph_quad_generator_top_test.sv
